>>> src/magnetometer_heading_assert.svh
// assertion macros shared by the magnetometer heading modules
`ifndef MAGNETOMETER_HEADING_ASSERT_SVH
`define MAGNETOMETER_HEADING_ASSERT_SVH

// same-cycle implication, checked while out of reset
`define MH_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("magnetometer heading check failed");

// next-cycle implication, checked while out of reset
`define MH_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("magnetometer heading check failed");

`endif

>>> src/mh_pkg.sv
// shared types, constants and tables for the magnetometer heading block
package mh_pkg;

    localparam int SAMPLE_W = 16;
    localparam int CFG_W    = 16;
    localparam int DEC_W    = 9;
    localparam int IDX_W    = 3;

    localparam logic [IDX_W-1:0] REG_X_MIN = 3'd0;
    localparam logic [IDX_W-1:0] REG_X_MAX = 3'd1;
    localparam logic [IDX_W-1:0] REG_Y_MIN = 3'd2;
    localparam logic [IDX_W-1:0] REG_Y_MAX = 3'd3;
    localparam logic [IDX_W-1:0] REG_Z_MIN = 3'd4;
    localparam logic [IDX_W-1:0] REG_Z_MAX = 3'd5;
    localparam logic [IDX_W-1:0] REG_DECL  = 3'd6;

    localparam logic signed [CFG_W-1:0] X_MIN_RST = -16'sd5632;
    localparam logic signed [CFG_W-1:0] X_MAX_RST = 16'sd7152;
    localparam logic signed [CFG_W-1:0] Y_MIN_RST = -16'sd7112;
    localparam logic signed [CFG_W-1:0] Y_MAX_RST = 16'sd6327;
    localparam logic signed [CFG_W-1:0] Z_MIN_RST = -16'sd6085;
    localparam logic signed [CFG_W-1:0] Z_MAX_RST = 16'sd5785;
    localparam logic signed [DEC_W-1:0] DECL_RST  = 9'sd0;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int SAMPLE_BITS_DEF  = 16;
    localparam int QUEUE_DEPTH      = 4;

    // numerator magnitude, span magnitude, scaled dividend, quotient bits
    localparam int NMAG_W = 17;
    localparam int DMAG_W = 16;
    localparam int DIVN_W = 29;
    localparam int QUO_W  = 17;
    localparam int CMP_W  = 33;

    localparam int PX_W = 36;
    localparam int Z_W  = 35;
    localparam int AZ_LIMIT = 25736;
    localparam logic [33:0] PI_FIX      = 34'hC90FDAA0;
    localparam logic [33:0] HALF_PI_FIX = 34'h6487ED50;

    typedef struct packed {
        logic              num_neg;
        logic              den_neg;
        logic              num_zero;
        logic              den_zero;
        logic [NMAG_W-1:0] nmag;
        logic [DMAG_W-1:0] dmag;
    } axis_item_t;

    typedef struct packed {
        axis_item_t x;
        axis_item_t y;
        axis_item_t z;
    } norm_item_t;

    // atan(2^-i) scaled by 2^30
    function automatic logic [31:0] atan_entry(input int i);
        logic [31:0] v;
        case (i)
            0:       v = 32'h3243F6A8;
            1:       v = 32'h1DAC6705;
            2:       v = 32'h0FADBAFC;
            3:       v = 32'h07F56EA6;
            4:       v = 32'h03FEAB76;
            5:       v = 32'h01FFD55B;
            6:       v = 32'h00FFFAAA;
            7:       v = 32'h007FFF55;
            8:       v = 32'h003FFFEA;
            9:       v = 32'h001FFFFD;
            10:      v = 32'h000FFFFF;
            11:      v = 32'h0007FFFF;
            12:      v = 32'h0003FFFF;
            13:      v = 32'h0001FFFF;
            14:      v = 32'h0000FFFF;
            15:      v = 32'h00007FFF;
            16:      v = 32'h00003FFF;
            17:      v = 32'h00001FFF;
            18:      v = 32'h00000FFF;
            19:      v = 32'h000007FF;
            20:      v = 32'h000003FF;
            21:      v = 32'h000001FF;
            22:      v = 32'h000000FF;
            23:      v = 32'h0000007F;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

>>> src/magnetometer_heading.sv
// magnetometer heading: top level with configuration registers and stream ports
//
// One 48-bit sample transaction on s_ (x, y, z, signed 16 bit) gives one result
// transaction on m_: field radius Q4.12, azimuth Q3.13 radians, heading in whole
// degrees with declination applied, and a 16-point compass sector.
// Calibration min/max per axis and the declination are written through the
// cfg_ port, one register per cycle; the user must write them only while no
// transaction is in flight, as the block itself does not enforce it.
// From input acceptance to m_tvalid an item passes the input queue, 19 divider
// stages, squares and 17 root stages, a cordic set-up stage and one stage per
// step, a rounding stage, then five heading and output stages.
// Throughput is one transaction per cycle while the output is not held; every
// stage of the divider, root and cordic pipelines then takes a new item each cycle.
// When a result waits and m_tready is low the whole arithmetic pipeline holds; the
// four-entry input queue keeps taking samples until it fills, then s_tready drops.
// Synchronous active-low reset empties the queue and pipeline and restores the
// calibration registers to their reset values.
module magnetometer_heading #(
    parameter int CORDIC_STEPS = mh_pkg::CORDIC_STEPS_DEF,
    parameter int SAMPLE_BITS  = mh_pkg::SAMPLE_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [47:0]                     s_tdata,   // x_sample, y_sample, z_sample
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // field_radius, azimuth_rad, heading_degrees, compass_point, zero pad
    output logic [47:0]                     m_tdata,
    input  logic                            cfg_wr_en,
    input  logic [mh_pkg::IDX_W-1:0]        cfg_index,
    input  logic [mh_pkg::CFG_W-1:0]        cfg_wdata
);

    logic signed [mh_pkg::CFG_W-1:0] x_min_reg, x_max_reg, y_min_reg, y_max_reg;
    logic signed [mh_pkg::CFG_W-1:0] z_min_reg, z_max_reg;
    logic signed [mh_pkg::DEC_W-1:0] decl_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_min_reg <= mh_pkg::X_MIN_RST;
            x_max_reg <= mh_pkg::X_MAX_RST;
            y_min_reg <= mh_pkg::Y_MIN_RST;
            y_max_reg <= mh_pkg::Y_MAX_RST;
            z_min_reg <= mh_pkg::Z_MIN_RST;
            z_max_reg <= mh_pkg::Z_MAX_RST;
            decl_reg  <= mh_pkg::DECL_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                mh_pkg::REG_X_MIN: x_min_reg <= cfg_wdata;
                mh_pkg::REG_X_MAX: x_max_reg <= cfg_wdata;
                mh_pkg::REG_Y_MIN: y_min_reg <= cfg_wdata;
                mh_pkg::REG_Y_MAX: y_max_reg <= cfg_wdata;
                mh_pkg::REG_Z_MIN: z_min_reg <= cfg_wdata;
                mh_pkg::REG_Z_MAX: z_max_reg <= cfg_wdata;
                mh_pkg::REG_DECL:  decl_reg  <= cfg_wdata[mh_pkg::DEC_W-1:0];
                default: ;
            endcase
        end
    end

    mh_pkg::norm_item_t front_item, queue_item;
    logic q_full, q_empty, advance;

    mh_front #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_front (
        .x_sample (s_tdata[15:0]),
        .y_sample (s_tdata[31:16]),
        .z_sample (s_tdata[47:32]),
        .x_min    (x_min_reg),
        .x_max    (x_max_reg),
        .y_min    (y_min_reg),
        .y_max    (y_max_reg),
        .z_min    (z_min_reg),
        .z_max    (z_max_reg),
        .item     (front_item)
    );

    assign s_tready = !q_full;

    mh_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (s_tvalid),
        .din     (front_item),
        .pop     (advance),
        .dout    (queue_item),
        .full    (q_full),
        .empty   (q_empty)
    );

    logic               n_valid;
    logic signed [15:0] nx, ny, nz;

    mh_norm u_norm (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (advance),
        .in_valid  (!q_empty),
        .in_item   (queue_item),
        .out_valid (n_valid),
        .out_nx    (nx),
        .out_ny    (ny),
        .out_nz    (nz)
    );

    logic [15:0]        radius;
    logic signed [15:0] az;
    logic [8:0]         heading;
    logic [3:0]         point;

    mh_back #(
        .CORDIC_STEPS(CORDIC_STEPS)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .in_valid    (n_valid),
        .in_nx       (nx),
        .in_ny       (ny),
        .in_nz       (nz),
        .decl        (decl_reg),
        .m_tready    (m_tready),
        .advance     (advance),
        .out_valid   (m_tvalid),
        .out_radius  (radius),
        .out_az      (az),
        .out_heading (heading),
        .out_point   (point)
    );

    assign m_tdata = {3'b000, point, heading, az, radius};

endmodule

>>> src/mh_front.sv
// front end: sample sign extension, hard-iron numerator and span classification
module mh_front #(
    parameter int SAMPLE_BITS = mh_pkg::SAMPLE_BITS_DEF
) (
    input  logic signed [mh_pkg::SAMPLE_W-1:0] x_sample,
    input  logic signed [mh_pkg::SAMPLE_W-1:0] y_sample,
    input  logic signed [mh_pkg::SAMPLE_W-1:0] z_sample,
    input  logic signed [mh_pkg::CFG_W-1:0]    x_min,
    input  logic signed [mh_pkg::CFG_W-1:0]    x_max,
    input  logic signed [mh_pkg::CFG_W-1:0]    y_min,
    input  logic signed [mh_pkg::CFG_W-1:0]    y_max,
    input  logic signed [mh_pkg::CFG_W-1:0]    z_min,
    input  logic signed [mh_pkg::CFG_W-1:0]    z_max,
    output mh_pkg::norm_item_t                 item
);

    function automatic mh_pkg::axis_item_t classify(
        input logic signed [15:0] v,
        input logic signed [15:0] lo,
        input logic signed [15:0] hi
    );
        logic signed [17:0] num;
        logic signed [16:0] den;
        mh_pkg::axis_item_t a;
        num = (18'(v) <<< 1) - 18'(hi) - 18'(lo);
        den = 17'(hi) - 17'(lo);
        a.num_neg  = num[17];
        a.den_neg  = den[16];
        a.num_zero = (num == 18'sd0);
        a.den_zero = (den == 17'sd0);
        a.nmag     = num[17] ? 17'(-num) : 17'(num);
        a.dmag     = den[16] ? 16'(-den) : 16'(den);
        return a;
    endfunction

    logic signed [SAMPLE_BITS-1:0] xs_t, ys_t, zs_t;
    logic signed [15:0]            xs, ys, zs;

    assign xs_t = x_sample[SAMPLE_BITS-1:0];
    assign ys_t = y_sample[SAMPLE_BITS-1:0];
    assign zs_t = z_sample[SAMPLE_BITS-1:0];
    assign xs   = 16'(xs_t);
    assign ys   = 16'(ys_t);
    assign zs   = 16'(zs_t);

    assign item.x = classify(xs, x_min, x_max);
    assign item.y = classify(ys, y_min, y_max);
    assign item.z = classify(zs, z_min, z_max);

endmodule

>>> src/mh_queue.sv
// short queue between the front end and the arithmetic pipeline
module mh_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  mh_pkg::norm_item_t din,
    input  logic               pop,
    output mh_pkg::norm_item_t dout,
    output logic               full,
    output logic               empty
);
    `include "magnetometer_heading_assert.svh"

    localparam int DEPTH = mh_pkg::QUEUE_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    mh_pkg::norm_item_t mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0]   count_reg;
    logic               push_ok, pop_ok;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign push_ok = push && !full;
    assign pop_ok  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push_ok) begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push_ok) begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop_ok) begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + CNT_W'(push_ok) - CNT_W'(pop_ok);
        end
    end

    `MH_ASSERT_NOW(a_q_count_max, 1'b1, count_reg <= CNT_W'(DEPTH))
    `MH_ASSERT_NEXT(a_q_count_step, 1'b1, count_reg == $past(count_reg) + CNT_W'($past(push_ok)) - CNT_W'($past(pop_ok)))

endmodule

>>> src/mh_norm.sv
// pipelined restoring divider: scales each axis by its half-span into Q4.12
module mh_norm (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      en,
    input  logic                      in_valid,
    input  mh_pkg::norm_item_t        in_item,
    output logic                      out_valid,
    output logic signed [15:0]        out_nx,
    output logic signed [15:0]        out_ny,
    output logic signed [15:0]        out_nz
);

    localparam int STAGES = mh_pkg::QUO_W;

    typedef struct packed {
        logic [mh_pkg::DIVN_W-1:0] rem;
        logic [mh_pkg::QUO_W-1:0]  quo;
        logic [mh_pkg::DMAG_W-1:0] dmag;
        logic                      ov;
        logic                      num_neg;
        logic                      den_neg;
        logic                      num_zero;
        logic                      den_zero;
    } div_stage_t;

    function automatic div_stage_t load(input mh_pkg::axis_item_t a);
        div_stage_t s;
        logic [mh_pkg::DIVN_W-1:0] n;
        n          = {a.nmag, 12'b0};
        s.rem      = n;
        s.quo      = '0;
        s.dmag     = a.dmag;
        // quotient would not fit the quotient bits
        s.ov       = (mh_pkg::CMP_W'(n) >= (mh_pkg::CMP_W'(a.dmag) << mh_pkg::QUO_W));
        s.num_neg  = a.num_neg;
        s.den_neg  = a.den_neg;
        s.num_zero = a.num_zero;
        s.den_zero = a.den_zero;
        return s;
    endfunction

    function automatic div_stage_t step(input div_stage_t s, input int k);
        div_stage_t r;
        logic [mh_pkg::CMP_W-1:0] dsh;
        r   = s;
        dsh = mh_pkg::CMP_W'(s.dmag) << k;
        if (mh_pkg::CMP_W'(s.rem) >= dsh) begin
            r.rem = s.rem - dsh[mh_pkg::DIVN_W-1:0];
            r.quo = s.quo | (mh_pkg::QUO_W'(1) << k);
        end
        return r;
    endfunction

    function automatic logic signed [15:0] finish(input div_stage_t s);
        logic signed [15:0] v;
        if (s.den_zero) begin
            v = s.num_zero ? 16'sd0 : (s.num_neg ? -16'sd32768 : 16'sd32767);
        end else if (s.num_neg ^ s.den_neg) begin
            if (s.ov || (s.quo > 17'd32768)) begin
                v = -16'sd32768;
            end else begin
                v = 16'(-s.quo);
            end
        end else begin
            if (s.ov || (s.quo > 17'd32767)) begin
                v = 16'sd32767;
            end else begin
                v = s.quo[15:0];
            end
        end
        return v;
    endfunction

    logic       v_reg [0:STAGES];
    div_stage_t sx_reg [0:STAGES];
    div_stage_t sy_reg [0:STAGES];
    div_stage_t sz_reg [0:STAGES];
    logic               out_valid_reg;
    logic signed [15:0] nx_reg, ny_reg, nz_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg[0] <= 1'b0;
        end else if (en) begin
            v_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sx_reg[0] <= load(in_item.x);
            sy_reg[0] <= load(in_item.y);
            sz_reg[0] <= load(in_item.z);
        end
    end

    for (genvar g = 0; g < STAGES; g++) begin : g_div
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                v_reg[g+1] <= 1'b0;
            end else if (en) begin
                v_reg[g+1] <= v_reg[g];
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                sx_reg[g+1] <= step(sx_reg[g], STAGES - 1 - g);
                sy_reg[g+1] <= step(sy_reg[g], STAGES - 1 - g);
                sz_reg[g+1] <= step(sz_reg[g], STAGES - 1 - g);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= v_reg[STAGES];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            nx_reg <= finish(sx_reg[STAGES]);
            ny_reg <= finish(sy_reg[STAGES]);
            nz_reg <= finish(sz_reg[STAGES]);
        end
    end

    assign out_valid = out_valid_reg;
    assign out_nx    = nx_reg;
    assign out_ny    = ny_reg;
    assign out_nz    = nz_reg;

endmodule

>>> src/mh_back.sv
// back end: radius by square root, azimuth by cordic, heading and compass sector
module mh_back #(
    parameter int CORDIC_STEPS = mh_pkg::CORDIC_STEPS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            in_valid,
    input  logic signed [15:0]              in_nx,
    input  logic signed [15:0]              in_ny,
    input  logic signed [15:0]              in_nz,
    input  logic signed [mh_pkg::DEC_W-1:0] decl,
    input  logic                            m_tready,
    output logic                            advance,
    output logic                            out_valid,
    output logic [15:0]                     out_radius,
    output logic signed [15:0]              out_az,
    output logic [8:0]                      out_heading,
    output logic [3:0]                      out_point
);
    `include "magnetometer_heading_assert.svh"

    localparam int CS   = CORDIC_STEPS;
    localparam int PX_W = mh_pkg::PX_W;
    localparam int Z_W  = mh_pkg::Z_W;
    localparam logic signed [Z_W-1:0] PI_Z   = Z_W'(mh_pkg::PI_FIX);
    localparam logic signed [Z_W-1:0] HALF_Z = Z_W'(mh_pkg::HALF_PI_FIX);

    logic en;
    logic out_valid_reg;
    assign en      = !out_valid_reg || m_tready;
    assign advance = en;

    // squares
    logic               v_sq_reg;
    logic [30:0]        sqx_reg, sqy_reg, sqz_reg;
    logic signed [15:0] nx_sq_reg, ny_sq_reg;
    logic signed [31:0] px2, py2, pz2;

    assign px2 = in_nx * in_nx;
    assign py2 = in_ny * in_ny;
    assign pz2 = in_nz * in_nz;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_sq_reg <= 1'b0;
        end else if (en) begin
            v_sq_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sqx_reg   <= px2[30:0];
            sqy_reg   <= py2[30:0];
            sqz_reg   <= pz2[30:0];
            nx_sq_reg <= in_nx;
            ny_sq_reg <= in_ny;
        end
    end

    // square root, one result bit per stage
    logic               rv_reg   [0:16];
    logic [31:0]        rem_reg  [0:16];
    logic [15:0]        root_reg [0:16];
    logic signed [15:0] rx_reg   [0:16];
    logic signed [15:0] ry_reg   [0:16];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rv_reg[0] <= 1'b0;
        end else if (en) begin
            rv_reg[0] <= v_sq_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0]  <= 32'(sqx_reg) + 32'(sqy_reg) + 32'(sqz_reg);
            root_reg[0] <= '0;
            rx_reg[0]   <= nx_sq_reg;
            ry_reg[0]   <= ny_sq_reg;
        end
    end

    for (genvar g = 0; g < 16; g++) begin : g_sqrt
        localparam int B = 15 - g;
        logic [32:0] trial;
        logic        take;
        assign trial = (33'(root_reg[g]) << (B + 1)) + (33'(1) << (2 * B));
        assign take  = (33'(rem_reg[g]) >= trial);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                rv_reg[g+1] <= 1'b0;
            end else if (en) begin
                rv_reg[g+1] <= rv_reg[g];
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[g+1]  <= take ? rem_reg[g] - trial[31:0] : rem_reg[g];
                root_reg[g+1] <= take ? (root_reg[g] | (16'(1) << B)) : root_reg[g];
                rx_reg[g+1]   <= rx_reg[g];
                ry_reg[g+1]   <= ry_reg[g];
            end
        end
    end

    // cordic, vectoring mode
    logic                  cv_reg   [0:CS];
    logic signed [PX_W-1:0] cpx_reg [0:CS];
    logic signed [PX_W-1:0] cpy_reg [0:CS];
    logic signed [Z_W-1:0]  cz_reg  [0:CS];
    logic                  spec_reg [0:CS];
    logic [15:0]           crad_reg [0:CS];

    logic signed [PX_W-1:0] px0, py0;
    logic signed [15:0]     sx, sy;
    assign sx  = rx_reg[16];
    assign sy  = ry_reg[16];
    assign px0 = {{(PX_W-32){sx[15]}}, sx, 16'b0};
    assign py0 = {{(PX_W-32){sy[15]}}, sy, 16'b0};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cv_reg[0] <= 1'b0;
        end else if (en) begin
            cv_reg[0] <= rv_reg[16];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            crad_reg[0] <= root_reg[16];
            spec_reg[0] <= (sx == 16'sd0);
            if (sx == 16'sd0) begin
                // on the y line: straight to plus or minus pi/2
                cpx_reg[0] <= px0;
                cpy_reg[0] <= py0;
                cz_reg[0]  <= sy[15] ? -HALF_Z : HALF_Z;
            end else if (sx[15]) begin
                // left half plane: turn by pi first
                cpx_reg[0] <= -px0;
                cpy_reg[0] <= -py0;
                cz_reg[0]  <= sy[15] ? -PI_Z : PI_Z;
            end else begin
                cpx_reg[0] <= px0;
                cpy_reg[0] <= py0;
                cz_reg[0]  <= '0;
            end
        end
    end

    for (genvar g = 0; g < CS; g++) begin : g_cordic
        localparam logic signed [Z_W-1:0] ANG = Z_W'(mh_pkg::atan_entry(g));
        logic signed [PX_W-1:0] xs, ys;
        assign xs = cpx_reg[g] >>> g;
        assign ys = cpy_reg[g] >>> g;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                cv_reg[g+1] <= 1'b0;
            end else if (en) begin
                cv_reg[g+1] <= cv_reg[g];
            end
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                crad_reg[g+1] <= crad_reg[g];
                spec_reg[g+1] <= spec_reg[g];
                if (spec_reg[g]) begin
                    cpx_reg[g+1] <= cpx_reg[g];
                    cpy_reg[g+1] <= cpy_reg[g];
                    cz_reg[g+1]  <= cz_reg[g];
                end else if (cpy_reg[g] > 0) begin
                    cpx_reg[g+1] <= cpx_reg[g] + ys;
                    cpy_reg[g+1] <= cpy_reg[g] - xs;
                    cz_reg[g+1]  <= cz_reg[g] + ANG;
                end else begin
                    cpx_reg[g+1] <= cpx_reg[g] - ys;
                    cpy_reg[g+1] <= cpy_reg[g] + xs;
                    cz_reg[g+1]  <= cz_reg[g] - ANG;
                end
            end
        end
    end

    // angle to Q3.13, rounded half away from zero and clamped
    logic                   v_az_reg;
    logic signed [15:0]     az_reg;
    logic [15:0]            rad_az_reg;
    logic signed [Z_W-1:0]  zf;
    logic [Z_W-1:0]         zabs, zrnd;
    logic [Z_W-18:0]        zmag;
    logic [15:0]            zclamp;

    assign zf     = cz_reg[CS];
    assign zabs   = zf[Z_W-1] ? Z_W'(-zf) : Z_W'(zf);
    assign zrnd   = zabs + Z_W'(65536);
    assign zmag   = zrnd[Z_W-1:17];
    assign zclamp = (zmag > (Z_W-17)'(mh_pkg::AZ_LIMIT)) ? 16'(mh_pkg::AZ_LIMIT)
                                                         : zmag[15:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_az_reg <= 1'b0;
        end else if (en) begin
            v_az_reg <= cv_reg[CS];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            az_reg     <= zf[Z_W-1] ? -$signed(zclamp) : $signed(zclamp);
            rad_az_reg <= crad_reg[CS];
        end
    end

    // heading: degrees scaled by 81920 = 5 * 2^14
    logic               v_h1_reg, v_h2_reg, v_h3_reg, v_h4_reg;
    logic signed [25:0] prod_reg;
    logic signed [15:0] az_h1_reg, az_h2_reg, az_h3_reg, az_h4_reg;
    logic [15:0]        rad_h1_reg, rad_h2_reg, rad_h3_reg, rad_h4_reg;
    logic [11:0]        t_reg;
    logic               neg_reg;
    logic signed [10:0] h_reg;
    logic [8:0]         hd_reg;

    logic signed [10:0] dv;
    logic signed [27:0] base, num;
    logic [27:0]        nmag;
    logic [23:0]        p5;
    logic [9:0]         q5;
    logic [9:0]         s371;
    logic [8:0]         m360;
    logic [20:0]        pt;

    assign dv   = 11'sd360 + 11'(decl);
    assign base = (28'(dv) <<< 14) + (28'(dv) <<< 16);
    assign num  = base + 28'(prod_reg);
    assign nmag = num[27] ? 28'(-num) : 28'(num);
    // floor(t / 5) for t below 4096
    assign p5   = 24'(t_reg) * 24'd3277;
    assign q5   = p5[23:14];
    assign s371 = 10'(hd_reg) + 10'd371;
    assign m360 = (s371 >= 10'd720) ? 9'(s371 - 10'd720) : 9'(s371 - 10'd360);
    // floor(2m / 45) for m below 360
    assign pt   = 21'({m360, 1'b0}) * 21'd1457;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_h1_reg <= 1'b0;
            v_h2_reg <= 1'b0;
            v_h3_reg <= 1'b0;
            v_h4_reg <= 1'b0;
        end else if (en) begin
            v_h1_reg <= v_az_reg;
            v_h2_reg <= v_h1_reg;
            v_h3_reg <= v_h2_reg;
            v_h4_reg <= v_h3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            prod_reg   <= az_reg * 26'sd573;
            az_h1_reg  <= az_reg;
            rad_h1_reg <= rad_az_reg;

            t_reg      <= nmag[25:14];
            neg_reg    <= num[27];
            az_h2_reg  <= az_h1_reg;
            rad_h2_reg <= rad_h1_reg;

            h_reg      <= neg_reg ? -$signed({1'b0, q5}) : $signed({1'b0, q5});
            az_h3_reg  <= az_h2_reg;
            rad_h3_reg <= rad_h2_reg;

            if (h_reg < 0) begin
                hd_reg <= 9'(h_reg + 11'sd360);
            end else if (h_reg >= 11'sd720) begin
                hd_reg <= 9'(h_reg - 11'sd720);
            end else if (h_reg >= 11'sd360) begin
                hd_reg <= 9'(h_reg - 11'sd360);
            end else begin
                hd_reg <= 9'(h_reg);
            end
            az_h4_reg  <= az_h3_reg;
            rad_h4_reg <= rad_h3_reg;
        end
    end

    // output register
    logic [15:0]        out_radius_reg;
    logic signed [15:0] out_az_reg;
    logic [8:0]         out_heading_reg;
    logic [3:0]         out_point_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= v_h4_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            out_radius_reg  <= rad_h4_reg;
            out_az_reg      <= az_h4_reg;
            out_heading_reg <= hd_reg;
            out_point_reg   <= pt[19:16];
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_radius  = out_radius_reg;
    assign out_az      = out_az_reg;
    assign out_heading = out_heading_reg;
    assign out_point   = out_point_reg;

    `MH_ASSERT_NOW(a_heading_range, out_valid_reg, out_heading_reg <= 9'd359)
    `MH_ASSERT_NOW(a_az_range, out_valid_reg, (out_az_reg <= 16'sd25736) && (out_az_reg >= -16'sd25736))

endmodule
